### rtl/icr_pkg.sv
package icr_pkg;

   // register indices
   localparam logic [7:0] IDX_ISA_CLOCK  = 8'h10;
   localparam logic [7:0] IDX_CACHE      = 8'h11;
   localparam logic [7:0] IDX_HALT       = 8'h14;
   localparam logic [7:0] IDX_SHADOW_C   = 8'h15;
   localparam logic [7:0] IDX_ISA_FIXED  = 8'h1c;
   localparam logic [7:0] IDX_SMI_TRIG   = 8'h64;
   localparam logic [7:0] IDX_SMI_ENABLE = 8'h65;
   localparam logic [7:0] IDX_SMI_STATUS = 8'h6a;
   localparam logic [7:0] IDX_SHADOW_D   = 8'h6e;
   localparam logic [7:0] IDX_SHADOW_E   = 8'h6f;
   localparam logic [7:0] IDX_SMRAM      = 8'h70;
   localparam logic [7:0] IDX_HOLE       = 8'h7a;

   // green bank spans 0x60..0x7c
   localparam int unsigned GREEN_DEPTH = 29;
   localparam int unsigned LOW_DEPTH   = 16;

   // shadow access codes
   localparam logic [1:0] CODE_EXT  = 2'd0;
   localparam logic [1:0] CODE_INT  = 2'd1;
   localparam logic [1:0] CODE_ANY  = 2'd2;
   localparam logic [1:0] CODE_NONE = 2'd3;

   // CSR register indices
   localparam logic CSR_GREEN = 1'b0;

   // stored register bits used by the output decode
   typedef struct packed {
      logic [1:0] isa_div;
      logic       isa_fixed;
      logic       cache;
      logic       halt_reset;
      logic       smram;
      logic [7:0] shadow_c;
      logic [7:0] shadow_d;
      logic [7:0] shadow_e;
   } taps_type;

endpackage

### rtl/icr_regfile.sv
module icr_regfile (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              func,
   input  logic              port_select,
   input  logic [7:0]        write_data,
   input  logic              green,
   output logic [7:0]        read_data,
   output logic              smi_request,
   output icr_pkg::taps_type taps
);

   logic [7:0] index_ff, index_in;
   logic [7:0] low_bank_ff   [icr_pkg::LOW_DEPTH];
   logic [7:0] low_bank_in   [icr_pkg::LOW_DEPTH];
   logic [7:0] green_bank_ff [icr_pkg::GREEN_DEPTH];
   logic [7:0] green_bank_in [icr_pkg::GREEN_DEPTH];
   logic [7:0] status_ff     [2];
   logic [7:0] status_in     [2];
   logic       bank_sel_ff, bank_sel_in;

   logic in_low, in_green, wr_ok;

   assign in_low   = (index_ff[7:4] == 4'h1);
   assign in_green = (index_ff[7:5] == 3'b011) &&
                     (index_ff[4:0] <= 5'(icr_pkg::GREEN_DEPTH - 1));
   assign wr_ok    = in_low || (green && in_green && index_ff != icr_pkg::IDX_HOLE);

   always_comb begin
      index_in      = index_ff;
      low_bank_in   = low_bank_ff;
      green_bank_in = green_bank_ff;
      status_in     = status_ff;
      bank_sel_in   = bank_sel_ff;
      read_data     = 8'h00;
      smi_request   = 1'b0;
      if (func) begin
         if (!port_select) begin
            index_in = write_data;
         end else if (wr_ok) begin
            if (in_low) begin
               low_bank_in[index_ff[3:0]] = write_data;
            end else begin
               green_bank_in[index_ff[4:0]] = write_data;
            end
            if (index_ff == icr_pkg::IDX_SMI_TRIG && write_data[7]) begin
               smi_request  = green_bank_ff[icr_pkg::IDX_SMI_ENABLE[4:0]][7];
               status_in[0] = status_ff[0] | 8'h10;
            end else if (index_ff == icr_pkg::IDX_SMI_STATUS) begin
               bank_sel_in = write_data[7];
            end
         end
      end else begin
         if (!port_select) begin
            read_data = 8'hff;
         end else if (index_ff == icr_pkg::IDX_SMI_STATUS) begin
            // status read clears the selected bank
            read_data              = status_ff[bank_sel_ff];
            status_in[bank_sel_ff] = 8'h00;
         end else if (in_low) begin
            read_data = low_bank_ff[index_ff[3:0]];
         end else if (in_green) begin
            read_data = green_bank_ff[index_ff[4:0]];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff    <= 8'h00;
         bank_sel_ff <= 1'b0;
         for (int i = 0; i < icr_pkg::LOW_DEPTH; i++) low_bank_ff[i] <= 8'h00;
         for (int i = 0; i < icr_pkg::GREEN_DEPTH; i++) green_bank_ff[i] <= 8'h00;
         for (int i = 0; i < 2; i++) status_ff[i] <= 8'h00;
      end else if (advance) begin
         index_ff      <= index_in;
         bank_sel_ff   <= bank_sel_in;
         low_bank_ff   <= low_bank_in;
         green_bank_ff <= green_bank_in;
         status_ff     <= status_in;
      end
   end

   assign taps.isa_div    = low_bank_ff[icr_pkg::IDX_ISA_CLOCK[3:0]][1:0];
   assign taps.isa_fixed  = low_bank_ff[icr_pkg::IDX_ISA_FIXED[3:0]][1];
   assign taps.cache      = low_bank_ff[icr_pkg::IDX_CACHE[3:0]][0];
   assign taps.halt_reset = low_bank_ff[icr_pkg::IDX_HALT[3:0]][7];
   assign taps.smram      = green_bank_ff[icr_pkg::IDX_SMRAM[4:0]][2];
   assign taps.shadow_c   = low_bank_ff[icr_pkg::IDX_SHADOW_C[3:0]];
   assign taps.shadow_d   = green_bank_ff[icr_pkg::IDX_SHADOW_D[4:0]];
   assign taps.shadow_e   = green_bank_ff[icr_pkg::IDX_SHADOW_E[4:0]];

endmodule

### rtl/icr_decode.sv
module icr_decode (
   input  icr_pkg::taps_type taps,
   input  logic              green,
   output logic [2:0]        isa_clock_select,
   output logic              cache_enable,
   output logic              reset_on_halt,
   output logic              smram_high_enable,
   output logic [51:0]       shadow_map,
   output logic [1:0]        bios_shadow_flags
);

   // four 16KB regions under one control byte; the clear codes apply
   // to a shadowed region whose write-protect bit is clear
   function automatic logic [15:0] segment_map(input logic [7:0] r,
                                               input logic [3:0] clear_code);
      logic [15:0] m;
      m = 16'h0000;
      for (int i = 0; i < 4; i++) begin
         if (r[0]) begin
            m[4*i +: 4] = {icr_pkg::CODE_ANY, icr_pkg::CODE_ANY};
         end else if (r[i+2]) begin
            m[4*i +: 4] = r[1] ? {icr_pkg::CODE_EXT, icr_pkg::CODE_INT} : clear_code;
         end else begin
            m[4*i +: 4] = {icr_pkg::CODE_EXT, icr_pkg::CODE_EXT};
         end
      end
      return m;
   endfunction

   logic [3:0] f_code;
   logic       e_shadowed;

   assign isa_clock_select  = taps.isa_fixed ? 3'd0 : {1'b0, taps.isa_div} + 3'd1;
   assign cache_enable      = taps.cache;
   assign reset_on_halt     = taps.halt_reset;
   assign smram_high_enable = green && taps.smram;

   // code nibble is {write, read}
   assign f_code = taps.shadow_c[7] ? {icr_pkg::CODE_ANY, icr_pkg::CODE_INT}
                                    : {icr_pkg::CODE_INT, icr_pkg::CODE_ANY};

   assign shadow_map[3:0]  = f_code;
   assign shadow_map[19:4] = segment_map(taps.shadow_c,
                                         {icr_pkg::CODE_INT, icr_pkg::CODE_EXT});
   assign shadow_map[35:20] = green ?
      segment_map(taps.shadow_d, {icr_pkg::CODE_INT, icr_pkg::CODE_INT}) : '1;
   assign shadow_map[51:36] = green ?
      segment_map(taps.shadow_e, {icr_pkg::CODE_INT, icr_pkg::CODE_INT}) : '1;

   assign e_shadowed = green && !taps.shadow_e[0] && (taps.shadow_e[5:2] != 4'h0);

   assign bios_shadow_flags[0] = taps.shadow_c[7] || e_shadowed;
   assign bios_shadow_flags[1] = !taps.shadow_c[7] || (e_shadowed && !taps.shadow_e[1]);

endmodule

### rtl/indexed_chipset_config_registers_unit.sv
// channel   dir  tdata (low bit up)                               tuser
// req_      in   write_data[7:0]                                  func, port_select
// rsp_      out  read_data[7:0], smi_request, isa_clock_select,   -
//                cache_enable, reset_on_halt, smram_high_enable,
//                shadow_map[51:0], bios_shadow_flags[1:0], pad
// csr_      in   APB, one register: green_variant at 0x0
//
// One request per cycle while rsp_ does not stall. A request sits in the input
// register, is decoded and updates the register file on the edge that moves its
// result to the output register. The input register frees as soon as the result
// moves on; a stall on rsp_ holds both registers. Synchronous reset clears index,
// register banks, SMI status and green_variant.
module indexed_chipset_config_registers_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // write_data[7:0]
   input  logic [1:0]  req_tuser,    // func[0], port_select[1]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,    // read_data[7:0], smi_request[8],
                                     // isa_clock_select[11:9], cache_enable[12],
                                     // reset_on_halt[13], smram_high_enable[14],
                                     // shadow_map[66:15], bios_shadow_flags[68:67]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic       in_valid_ff;
   logic [7:0] in_data_ff;
   logic [1:0] in_user_ff;
   logic       out_valid_ff;
   logic [7:0] rd_ff;
   logic       smi_ff;
   logic       green_ff;
   logic       advance;

   logic [7:0]        rd_in;
   logic              smi_in;
   icr_pkg::taps_type taps;
   logic [2:0]        isa_clock_select;
   logic              cache_enable, reset_on_halt, smram_high_enable;
   logic [51:0]       shadow_map;
   logic [1:0]        bios_shadow_flags;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) in_valid_ff <= req_tvalid;
         if (!out_valid_ff || rsp_tready) out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_data_ff <= req_tdata;
         in_user_ff <= req_tuser;
      end
      if (advance) begin
         rd_ff  <= rd_in;
         smi_ff <= smi_in;
      end
   end

   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         green_ff <= 1'b0;
      end else if (csr_psel && csr_penable && csr_pwrite &&
                   csr_paddr[2] == icr_pkg::CSR_GREEN) begin
         green_ff <= csr_pwdata[0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == icr_pkg::CSR_GREEN) ? {31'b0, green_ff} : 32'h0;

   icr_regfile u_regfile (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .func        (in_user_ff[0]),
      .port_select (in_user_ff[1]),
      .write_data  (in_data_ff),
      .green       (green_ff),
      .read_data   (rd_in),
      .smi_request (smi_in),
      .taps        (taps)
   );

   // register state always matches the request held in the output register
   icr_decode u_decode (
      .taps              (taps),
      .green             (green_ff),
      .isa_clock_select  (isa_clock_select),
      .cache_enable      (cache_enable),
      .reset_on_halt     (reset_on_halt),
      .smram_high_enable (smram_high_enable),
      .shadow_map        (shadow_map),
      .bios_shadow_flags (bios_shadow_flags)
   );

   assign rsp_tdata = {3'b000, bios_shadow_flags, shadow_map, smram_high_enable,
                       reset_on_halt, cache_enable, isa_clock_select, smi_ff, rd_ff};

endmodule

### verif/tb_indexed_chipset_config_registers_unit.sv
`timescale 1ns / 1ps

module tb_indexed_chipset_config_registers_unit;

   localparam int QUIET_LIMIT = 500;
   localparam logic [7:0] LOW_FIRST   = 8'h10;
   localparam logic [7:0] LOW_LAST    = 8'h1f;
   localparam logic [7:0] GREEN_FIRST = 8'h60;
   localparam logic [7:0] GREEN_LAST  = 8'h7c;
   localparam logic FUNC_READ  = 1'b0;
   localparam logic FUNC_WRITE = 1'b1;
   localparam logic PORT_INDEX = 1'b0;
   localparam logic PORT_DATA  = 1'b1;

   // rsp_tdata layout, lowest bit last
   typedef struct packed {
      logic [2:0]  pad;
      logic [1:0]  bios_flags;
      logic [51:0] shadow;
      logic        smram;
      logic        halt;
      logic        cache;
      logic [2:0]  isa_clock;
      logic        smi;
      logic [7:0]  read_data;
   } access_result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;    // write_data[7:0]
   logic [1:0]  req_tuser;    // func[0], port_select[1]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;    // read_data, smi_request, isa_clock_select, cache_enable,
                              // reset_on_halt, smram_high_enable, shadow_map,
                              // bios_shadow_flags, pad
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   class chipset_port_tracker;
      logic [7:0]        regs [256];
      logic [7:0]        status_bank [2];
      logic              bank_sel;
      logic [7:0]        index;
      logic              green;
      access_result_type due_responses [$];
      int                errors;
      int                requests;
      int                responses;
      int                smi_seen;
      int                status_reads;

      function new();
         foreach (regs[i]) regs[i] = 8'h00;
         status_bank[0] = 8'h00;
         status_bank[1] = 8'h00;
         bank_sel = 1'b0;
         index = 8'h00;
         green = 1'b0;
         errors = 0;
         requests = 0;
         responses = 0;
         smi_seen = 0;
         status_reads = 0;
      endfunction

      function logic accepts_write(logic [7:0] idx);
         if (idx >= GREEN_FIRST && !green) return 1'b0;
         if (idx >= LOW_FIRST && idx <= LOW_LAST) return 1'b1;
         return idx >= GREEN_FIRST && idx <= GREEN_LAST && idx != icr_pkg::IDX_HOLE;
      endfunction

      // four 16KB regions; the clear codes apply when shadowed with bit1 low
      function logic [15:0] segment_codes(logic [7:0] r, logic [1:0] clr_rd,
                                          logic [1:0] clr_wr);
         logic [15:0] m;
         m = '0;
         for (int i = 0; i < 4; i++) begin
            if (r[0])
               m[4*i +: 4] = {icr_pkg::CODE_ANY, icr_pkg::CODE_ANY};
            else if (r[i+2])
               m[4*i +: 4] = r[1] ? {icr_pkg::CODE_EXT, icr_pkg::CODE_INT}
                                  : {clr_wr, clr_rd};
            else
               m[4*i +: 4] = {icr_pkg::CODE_EXT, icr_pkg::CODE_EXT};
         end
         return m;
      endfunction

      function void note_access(logic is_write, logic data_port, logic [7:0] wd);
         access_result_type r;
         logic [7:0]        shadow_e;
         r = '0;
         if (is_write) begin
            if (data_port == PORT_INDEX) begin
               index = wd;
            end else if (accepts_write(index)) begin
               regs[index] = wd;
               if (index == icr_pkg::IDX_SMI_TRIG && wd[7]) begin
                  r.smi = regs[icr_pkg::IDX_SMI_ENABLE][7];
                  status_bank[0][4] = 1'b1;
               end else if (index == icr_pkg::IDX_SMI_STATUS) begin
                  bank_sel = wd[7];
               end
            end
         end else if (data_port == PORT_INDEX) begin
            r.read_data = 8'hff;
         end else if (index == icr_pkg::IDX_SMI_STATUS) begin
            // read-to-clear on the selected bank, green or not
            r.read_data = status_bank[bank_sel];
            status_bank[bank_sel] = 8'h00;
            status_reads++;
         end else begin
            r.read_data = regs[index];
         end

         r.isa_clock = regs[icr_pkg::IDX_ISA_FIXED][1] ? 3'd0
                     : 3'd1 + {1'b0, regs[icr_pkg::IDX_ISA_CLOCK][1:0]};
         r.cache = regs[icr_pkg::IDX_CACHE][0];
         r.halt = regs[icr_pkg::IDX_HALT][7];
         r.smram = green & regs[icr_pkg::IDX_SMRAM][2];
         if (regs[icr_pkg::IDX_SHADOW_C][7]) begin
            r.shadow[3:0] = {icr_pkg::CODE_ANY, icr_pkg::CODE_INT};
            r.bios_flags[0] = 1'b1;
         end else begin
            r.shadow[3:0] = {icr_pkg::CODE_INT, icr_pkg::CODE_ANY};
            r.bios_flags[1] = 1'b1;
         end
         r.shadow[19:4] = segment_codes(regs[icr_pkg::IDX_SHADOW_C],
                                        icr_pkg::CODE_EXT, icr_pkg::CODE_INT);
         if (green) begin
            shadow_e = regs[icr_pkg::IDX_SHADOW_E];
            r.shadow[35:20] = segment_codes(regs[icr_pkg::IDX_SHADOW_D],
                                            icr_pkg::CODE_INT, icr_pkg::CODE_INT);
            r.shadow[51:36] = segment_codes(shadow_e, icr_pkg::CODE_INT,
                                            icr_pkg::CODE_INT);
            if (!shadow_e[0] && shadow_e[5:2] != 4'h0) begin
               r.bios_flags[0] = 1'b1;
               if (!shadow_e[1]) r.bios_flags[1] = 1'b1;
            end
         end else begin
            r.shadow[51:20] = '1;
         end

         requests++;
         if (r.smi) smi_seen++;
         due_responses.push_back(r);
      endfunction

      function void compare_field(string name, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_response(logic [71:0] word);
         access_result_type got;
         access_result_type want;
         got = word;
         responses++;
         if (due_responses.size() == 0) begin
            $display("%0t: response with nothing pending, expected none, actual %h",
                     $time, word);
            errors++;
            return;
         end
         want = due_responses.pop_front();
         compare_field("read_data", 64'(want.read_data), 64'(got.read_data));
         compare_field("smi_request", 64'(want.smi), 64'(got.smi));
         compare_field("isa_clock_select", 64'(want.isa_clock), 64'(got.isa_clock));
         compare_field("cache_enable", 64'(want.cache), 64'(got.cache));
         compare_field("reset_on_halt", 64'(want.halt), 64'(got.halt));
         compare_field("smram_high_enable", 64'(want.smram), 64'(got.smram));
         compare_field("shadow_map", 64'(want.shadow), 64'(got.shadow));
         compare_field("bios_shadow_flags", 64'(want.bios_flags), 64'(got.bios_flags));
      endfunction
   endclass

   chipset_port_tracker tracker = new();
   int quiet_cycles = 0;
   int send_steady = 0;
   int phases = 0;

   indexed_chipset_config_registers_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable && csr_pwrite && csr_pready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no handshake for %0d cycles, %0d responses outstanding",
                  $time, quiet_cycles, tracker.due_responses.size());
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // response side: random stall after each response, with steady stretches
   initial begin
      int stall;
      int steady;
      stall = 0;
      steady = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            tracker.check_response(rsp_tdata);
            if (steady > 0) begin
               stall = 0;
               steady--;
            end else begin
               stall = $urandom_range(0, 12);
               if ($urandom_range(0, 19) == 0) steady = $urandom_range(8, 30);
            end
         end
         @(negedge clock);
         rsp_tready = (stall == 0);
         if (stall > 0) stall--;
      end
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_access(logic is_write, logic data_port, logic [7:0] wd);
      int gap;
      if (send_steady > 0) begin
         gap = 0;
         send_steady--;
      end else begin
         gap = $urandom_range(0, 12);
         if ($urandom_range(0, 19) == 0) send_steady = $urandom_range(8, 30);
      end
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = wd;
      req_tuser = {data_port, is_write};
      do @(posedge clock); while (!req_tready);
      tracker.note_access(is_write, data_port, wd);
      @(negedge clock);
   endtask

   task automatic set_register(logic [7:0] idx, logic [7:0] value);
      send_access(FUNC_WRITE, PORT_INDEX, idx);
      send_access(FUNC_WRITE, PORT_DATA, value);
   endtask

   task automatic read_register(logic [7:0] idx);
      send_access(FUNC_WRITE, PORT_INDEX, idx);
      send_access(FUNC_READ, PORT_DATA, 8'h00);
   endtask

   task automatic drain_responses();
      req_tvalid = 1'b0;
      while (tracker.due_responses.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic csr_write(logic [31:0] value);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b1;
      csr_paddr = {icr_pkg::CSR_GREEN, 2'b00};
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      tracker.green = value[0];
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      phases++;
   endtask

   function automatic logic [7:0] pick_index();
      logic [7:0] idx;
      case ($urandom_range(0, 9))
         0, 1, 2: idx = 8'($urandom_range(LOW_FIRST, LOW_LAST));
         3, 4, 5: idx = 8'($urandom_range(GREEN_FIRST, GREEN_LAST));
         6, 7: begin
            case ($urandom_range(0, 11))
               0: idx = icr_pkg::IDX_ISA_CLOCK;
               1: idx = icr_pkg::IDX_CACHE;
               2: idx = icr_pkg::IDX_HALT;
               3: idx = icr_pkg::IDX_SHADOW_C;
               4: idx = icr_pkg::IDX_ISA_FIXED;
               5: idx = icr_pkg::IDX_SMI_TRIG;
               6: idx = icr_pkg::IDX_SMI_ENABLE;
               7: idx = icr_pkg::IDX_SMI_STATUS;
               8: idx = icr_pkg::IDX_SHADOW_D;
               9: idx = icr_pkg::IDX_SHADOW_E;
               10: idx = icr_pkg::IDX_SMRAM;
               default: idx = icr_pkg::IDX_HOLE;
            endcase
         end
         default: idx = 8'($urandom_range(0, 255));
      endcase
      return idx;
   endfunction

   // mostly index write followed by a few data accesses; the rest is noise
   task automatic random_traffic(int count);
      int issued;
      int n;
      issued = 0;
      while (issued < count) begin
         if ($urandom_range(0, 59) == 0) drain_responses();
         case ($urandom_range(0, 9))
            7: begin
               send_access(FUNC_READ, PORT_INDEX, 8'($urandom_range(0, 255)));
               issued++;
            end
            8: begin
               send_access(1'($urandom_range(0, 1)), PORT_DATA,
                           8'($urandom_range(0, 255)));
               issued++;
            end
            9: begin
               send_access(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           8'($urandom_range(0, 255)));
               issued++;
            end
            default: begin
               send_access(FUNC_WRITE, PORT_INDEX, pick_index());
               n = $urandom_range(1, 3);
               repeat (n) send_access($urandom_range(0, 9) < 6, PORT_DATA,
                                      8'($urandom_range(0, 255)));
               issued += 1 + n;
            end
         endcase
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = 8'h00;
      req_tuser = 2'b00;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = 3'd0;
      csr_pwdata = 32'h0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // green off: base registers, green writes dropped, status read still live
      csr_write(32'h0);
      send_access(FUNC_READ, PORT_INDEX, 8'h00);
      set_register(icr_pkg::IDX_ISA_CLOCK, 8'h03);
      set_register(icr_pkg::IDX_ISA_FIXED, 8'h02);
      set_register(icr_pkg::IDX_SHADOW_C, 8'hff);
      set_register(icr_pkg::IDX_SMI_TRIG, 8'h80);
      read_register(icr_pkg::IDX_SMI_STATUS);
      drain_responses();

      // green on: SMI pulse, status banks, E shadow, SMRAM, the hole at 0x7a
      csr_write(32'h1);
      set_register(icr_pkg::IDX_SMI_ENABLE, 8'h80);
      set_register(icr_pkg::IDX_SMI_TRIG, 8'h80);
      read_register(icr_pkg::IDX_SMI_STATUS);
      set_register(icr_pkg::IDX_SMI_STATUS, 8'h80);
      send_access(FUNC_READ, PORT_DATA, 8'h00);
      set_register(icr_pkg::IDX_SHADOW_E, 8'h3c);
      set_register(icr_pkg::IDX_SMRAM, 8'h04);
      set_register(icr_pkg::IDX_HOLE, 8'hff);
      send_access(FUNC_READ, PORT_DATA, 8'h00);

      random_traffic(150);
      drain_responses();
      csr_write(32'h0);
      random_traffic(100);
      drain_responses();
      csr_write(32'hffff_ffff);
      random_traffic(150);
      drain_responses();
      repeat (10) @(posedge clock);

      $display("%0d requests and %0d responses over %0d green settings",
               tracker.requests, tracker.responses, phases);
      $display("%0d SMI pulses, %0d status bank reads, %0d mismatches",
               tracker.smi_seen, tracker.status_reads, tracker.errors);
      if (tracker.errors == 0 && tracker.due_responses.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
